// ===== rtl/plr_pkg.sv =====
// ----------------------------------------------------------------------------
// plr_pkg
// Shared types, constants and helpers for the peer longest-prefix lookup.
// ----------------------------------------------------------------------------
package plr_pkg;

    // default number of table entries
    localparam int PLR_DEPTH = 16;
    // index and count widths sized for the largest supported table
    localparam int IDX_W     = 8;
    localparam int CNT_W     = 9;
    localparam int ADDR_W    = 32;
    localparam int LEN_W     = 6;
    localparam int TAG_W     = 16;
    localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(32);

    typedef enum logic [1:0] {
        ST_INSERTED = 2'd0,
        ST_FULL     = 2'd1,
        ST_MATCH    = 2'd2,
        ST_NOMATCH  = 2'd3
    } t_status;

    typedef enum logic {
        MODE_INSERT = 1'b0,
        MODE_LOOKUP = 1'b1
    } t_mode;

    // item travelling down the cell chain
    typedef struct packed {
        t_mode             mode;
        logic [ADDR_W-1:0] addr;
        logic [LEN_W-1:0]  len;       // saturated insert length
        logic [TAG_W-1:0]  tag;
        logic [CNT_W-1:0]  cnt;       // entries valid for this item
        logic              full;      // insert rejected
        logic              found;     // lookup has a hit
        logic [IDX_W-1:0]  best_idx;  // insert slot or best hit
        logic [LEN_W-1:0]  best_len;
    } t_pkt;

    // network mask for a prefix length of 0 to 32
    function automatic logic [ADDR_W-1:0] prefix_mask(input logic [LEN_W-1:0] len);
        logic [ADDR_W-1:0] m;
        if (len == '0) begin
            m = '0;
        end else if (len >= MAX_LEN) begin
            m = '1;
        end else begin
            m = ~({ADDR_W{1'b1}} >> len);
        end
        return m;
    endfunction

endpackage

// ===== rtl/peer_longest_prefix_lookup_top.sv =====
// ----------------------------------------------------------------------------
// peer_longest_prefix_lookup_top
// Peer table with append insert and longest-prefix lookup over a cell chain.
// ----------------------------------------------------------------------------
// Each table entry lives in its own cell; an accepted item passes the entry
// register and then each cell's stage register in turn on its way to its
// result. The chain is a pipeline: a new item can be accepted every cycle,
// and the whole chain stalls while a result waits on o_ready. Inserts write
// the cell at the current fill count, and a lookup only considers entries
// that were inserted before it, so issue order is always honored.
module peer_longest_prefix_lookup_top
    import plr_pkg::*;
#(
    parameter int TABLE_DEPTH = PLR_DEPTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              i_ready,
    input  logic              i_mode,
    input  logic [ADDR_W-1:0] i_address,
    input  logic [LEN_W-1:0]  i_prefix_len,
    input  logic [TAG_W-1:0]  i_name_tag,
    output logic              o_valid,
    input  logic              o_ready,
    output logic [1:0]        o_status,
    output logic [3:0]        o_entry_index,
    output logic [LEN_W-1:0]  o_matched_len
);

    logic                    en;
    logic                    acc;
    logic                    full;
    logic [CNT_W-1:0]        r_count;
    logic                    r_vld0;
    t_pkt                    r_pkt0;
    t_pkt                    n_pkt0;
    logic [TABLE_DEPTH:0]    vld_c;
    t_pkt                    pkt_c [TABLE_DEPTH+1];
    t_pkt                    last;
    t_status                 st;

    // chain advances unless a result is held
    assign en      = !vld_c[TABLE_DEPTH] || o_ready;
    assign i_ready = en;
    assign acc     = i_valid && en;
    assign full    = r_count == CNT_W'(TABLE_DEPTH);

    // fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (acc && i_mode == MODE_INSERT && !full) begin
            r_count <= r_count + CNT_W'(1);
        end
    end

    // build the item entering the chain
    always_comb begin
        n_pkt0          = '0;
        n_pkt0.mode     = t_mode'(i_mode);
        n_pkt0.addr     = i_address;
        n_pkt0.len      = (i_prefix_len > MAX_LEN) ? MAX_LEN : i_prefix_len;
        n_pkt0.tag      = i_name_tag;
        n_pkt0.cnt      = r_count;
        n_pkt0.full     = full;
        n_pkt0.found    = 1'b0;
        n_pkt0.best_idx = (i_mode == MODE_INSERT && !full) ? r_count[IDX_W-1:0] : '0;
        n_pkt0.best_len = '0;
    end

    // entry register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld0 <= 1'b0;
        end else if (en) begin
            r_vld0 <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_pkt0 <= n_pkt0;
        end
    end

    assign vld_c[0] = r_vld0;
    assign pkt_c[0] = r_pkt0;

    // one cell per entry
    for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
        plr_cell #(
            .INDEX (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_vld   (vld_c[g]),
            .i_pkt   (pkt_c[g]),
            .o_vld   (vld_c[g+1]),
            .o_pkt   (pkt_c[g+1])
        );
    end

    // result from the chain tail
    assign last = pkt_c[TABLE_DEPTH];

    always_comb begin
        if (last.mode == MODE_INSERT) begin
            st = last.full ? ST_FULL : ST_INSERTED;
        end else begin
            st = last.found ? ST_MATCH : ST_NOMATCH;
        end
    end

    assign o_valid       = vld_c[TABLE_DEPTH];
    assign o_status      = st;
    assign o_entry_index = last.best_idx[3:0];
    assign o_matched_len = last.best_len;

endmodule

// ===== rtl/plr_cell.sv =====
// ----------------------------------------------------------------------------
// plr_cell
// One table entry; stores it on a matching insert and scores passing lookups.
// ----------------------------------------------------------------------------
module plr_cell
    import plr_pkg::*;
#(
    parameter int INDEX = 0
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_en,
    input  logic i_vld,
    input  t_pkt i_pkt,
    output logic o_vld,
    output t_pkt o_pkt
);

    logic [ADDR_W-1:0] r_addr;
    logic [LEN_W-1:0]  r_len;
    logic [TAG_W-1:0]  r_tag;
    logic              r_vld;
    t_pkt              r_pkt;
    t_pkt              n_pkt;
    logic              wr_hit;
    logic              in_use;
    logic              addr_ok;
    logic              tag_ok;
    logic [ADDR_W-1:0] mask;

    // insert targets this cell
    assign wr_hit = i_vld && (i_pkt.mode == MODE_INSERT) && !i_pkt.full &&
                    (i_pkt.best_idx == IDX_W'(INDEX));

    // entry is below the count the lookup was issued against
    assign in_use  = i_pkt.cnt > CNT_W'(INDEX);
    assign mask    = prefix_mask(r_len);
    assign addr_ok = (r_addr & mask) == (i_pkt.addr & mask);
    assign tag_ok  = (i_pkt.tag == '0) || (r_tag == '0) || (r_tag == i_pkt.tag);

    // keep the longer hit, earlier entry on a tie
    always_comb begin
        n_pkt = i_pkt;
        if (i_pkt.mode == MODE_LOOKUP && in_use && addr_ok && tag_ok &&
            (!i_pkt.found || r_len > i_pkt.best_len)) begin
            n_pkt.found    = 1'b1;
            n_pkt.best_idx = IDX_W'(INDEX);
            n_pkt.best_len = r_len;
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_en && wr_hit) begin
            r_addr <= i_pkt.addr;
            r_len  <= i_pkt.len;
            r_tag  <= i_pkt.tag;
        end
    end

    // stage register toward the next cell
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pkt <= n_pkt;
        end
    end

    assign o_vld = r_vld;
    assign o_pkt = r_pkt;

endmodule

// ===== rtl/plr_checker.sv =====
// ----------------------------------------------------------------------------
// plr_checker
// Port-level checks for the peer longest-prefix lookup, bound to the top.
// ----------------------------------------------------------------------------
module plr_checker
    import plr_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              o_valid,
    input logic              o_ready,
    input logic [1:0]        o_status,
    input logic [3:0]        o_entry_index,
    input logic [LEN_W-1:0]  o_matched_len
);

    // no result right after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    // held result keeps its payload
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_ready |=> o_valid && $stable(o_status) &&
            $stable(o_entry_index) && $stable(o_matched_len))
        else $error("held result changed");

    // insert results and misses carry no length
    a_no_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status == ST_INSERTED || o_status == ST_FULL ||
            o_status == ST_NOMATCH) |-> o_matched_len == '0)
        else $error("length on non-match result");

    // rejected inserts and misses report index zero
    a_no_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status == ST_FULL || o_status == ST_NOMATCH)
            |-> o_entry_index == '0)
        else $error("index on empty result");

    // matched length is a legal prefix
    a_len_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_matched_len <= MAX_LEN)
        else $error("matched length above 32");

endmodule

bind peer_longest_prefix_lookup_top plr_checker u_plr_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_valid       (o_valid),
    .o_ready       (o_ready),
    .o_status      (o_status),
    .o_entry_index (o_entry_index),
    .o_matched_len (o_matched_len)
);

// ===== sim/tb_peer_longest_prefix_lookup_top.sv =====
// ----------------------------------------------------------------------------
// tb_peer_longest_prefix_lookup_top
// Self-checking bench for the peer longest-prefix lookup table. A directed
// table fills every slot with edge-case entries, hits the full table and
// probes corner lookups. Random traffic follows: lookups built around
// stored prefixes, random noise and rejected inserts. All results are
// checked in order against a row's hand-written result, if it has one,
// else a local model of the table, under varying handshake pressure.
// ----------------------------------------------------------------------------
module tb_peer_longest_prefix_lookup_top;
    import plr_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int TBL_DEPTH   = PLR_DEPTH;
    localparam int CHAIN_LAT   = TBL_DEPTH + 1;
    localparam int RAND_ITEMS  = 642;
    localparam int HOLD_AT     = 1500;
    localparam int HOLD_CYCLES = 300;
    localparam int MAX_PRINTS  = 60;

    // one directed stimulus row, optionally with a hand-written result
    typedef struct {
        t_mode             mode;
        logic [ADDR_W-1:0] addr;
        logic [LEN_W-1:0]  plen;
        logic [TAG_W-1:0]  tag;
        bit                typed;
        t_status           status;
        logic [3:0]        idx;
        logic [LEN_W-1:0]  mlen;
    } t_stim_row;

    typedef struct {
        t_status          status;
        logic [3:0]       idx;
        logic [LEN_W-1:0] mlen;
    } t_lookup_result;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              i_valid;
    logic              i_ready;
    logic              i_mode;
    logic [ADDR_W-1:0] i_address;
    logic [LEN_W-1:0]  i_prefix_len;
    logic [TAG_W-1:0]  i_name_tag;
    logic              o_valid;
    logic              o_ready;
    logic [1:0]        o_status;
    logic [3:0]        o_entry_index;
    logic [LEN_W-1:0]  o_matched_len;

    // local copy of the peer table
    logic [ADDR_W-1:0] tbl_addr [TBL_DEPTH];
    logic [LEN_W-1:0]  tbl_len  [TBL_DEPTH];
    logic [TAG_W-1:0]  tbl_tag  [TBL_DEPTH];
    int                tbl_count = 0;

    t_lookup_result pending_results[$];
    t_stim_row      dir_rows[$];
    int             err_count    = 0;
    int             results_seen = 0;
    int             idle_phase   = 0;
    bit             hold_done    = 1'b0;

    peer_longest_prefix_lookup_top #(
        .TABLE_DEPTH(TBL_DEPTH)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .i_ready      (i_ready),
        .i_mode       (i_mode),
        .i_address    (i_address),
        .i_prefix_len (i_prefix_len),
        .i_name_tag   (i_name_tag),
        .o_valid      (o_valid),
        .o_ready      (o_ready),
        .o_status     (o_status),
        .o_entry_index(o_entry_index),
        .o_matched_len(o_matched_len)
    );

    always #2 i_clk = ~i_clk;

    // idle rates per phase: sender light first, then heavy, then none
    function automatic int tx_idle_pct();
        return (idle_phase == 0) ? 28 : (idle_phase == 1) ? 70 : 0;
    endfunction

    function automatic int rx_idle_pct();
        return (idle_phase == 0) ? 70 : (idle_phase == 1) ? 28 : 0;
    endfunction

    // network mask, built from the count of host bits
    function automatic logic [ADDR_W-1:0] len_mask(input logic [LEN_W-1:0] len);
        logic [63:0] host;
        host = (64'd1 << (32 - int'(len))) - 64'd1;
        return ~host[31:0];
    endfunction

    // applies one item to the local table and returns its answer
    function automatic t_lookup_result predict_peer_result(input t_mode m,
                                                           input logic [ADDR_W-1:0] a,
                                                           input logic [LEN_W-1:0] l,
                                                           input logic [TAG_W-1:0] t);
        t_lookup_result r;
        logic [ADDR_W-1:0] mk;
        bit hit;
        r.status = ST_NOMATCH;
        r.idx    = '0;
        r.mlen   = '0;
        hit      = 1'b0;
        if (m == MODE_INSERT) begin
            if (tbl_count >= TBL_DEPTH) begin
                r.status = ST_FULL;
            end else begin
                tbl_addr[tbl_count] = a;
                tbl_len[tbl_count]  = (l > 6'd32) ? 6'd32 : l;
                tbl_tag[tbl_count]  = t;
                r.status = ST_INSERTED;
                r.idx    = 4'(tbl_count);
                tbl_count++;
            end
        end else begin
            for (int k = 0; k < tbl_count; k++) begin
                mk = len_mask(tbl_len[k]);
                if (((tbl_addr[k] ^ a) & mk) == '0 &&
                    (t == '0 || tbl_tag[k] == '0 || tbl_tag[k] == t) &&
                    (!hit || tbl_len[k] > r.mlen)) begin
                    hit    = 1'b1;
                    r.idx  = 4'(k);
                    r.mlen = tbl_len[k];
                end
            end
            if (hit) begin
                r.status = ST_MATCH;
            end
        end
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        if (err_count < MAX_PRINTS) begin
            $display("%0t ns mismatch: %s", $time, msg);
        end
        err_count++;
    endtask

    // offers one item, with random gaps, and returns at its accepting edge
    task automatic offer_item(input t_mode m, input logic [ADDR_W-1:0] a,
                              input logic [LEN_W-1:0] l, input logic [TAG_W-1:0] t);
        bit took;
        while ($urandom_range(99) < tx_idle_pct()) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_mode       <= m;
        i_address    <= a;
        i_prefix_len <= l;
        i_name_tag   <= t;
        do begin
            @(negedge i_clk);
            took = i_ready;
            @(posedge i_clk);
        end while (!took);
    endtask

    // sender stops and waits until every pending result has come back
    task automatic drain_results();
        i_valid <= 1'b0;
        while (pending_results.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // receiver: random back pressure plus one long hold-off
    initial begin
        o_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (!hold_done && results_seen >= HOLD_AT) begin
                hold_done = 1'b1;
                o_ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(posedge i_clk);
            end else begin
                o_ready <= ($urandom_range(99) >= rx_idle_pct());
            end
        end
    end

    // result checker, sampled mid-cycle ahead of the accepting edge
    always @(negedge i_clk) begin
        t_lookup_result want;
        if (i_rst_n === 1'b1 && o_valid === 1'b1 && o_ready === 1'b1) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                report_mismatch($sformatf("result with no item pending: st=%0d idx=%0d len=%0d",
                                          o_status, o_entry_index, o_matched_len));
            end else begin
                want = pending_results.pop_front();
                if (o_status !== want.status || o_entry_index !== want.idx ||
                    o_matched_len !== want.mlen) begin
                    report_mismatch($sformatf("st=%0d idx=%0d len=%0d, want st=%0d idx=%0d len=%0d",
                                              o_status, o_entry_index, o_matched_len,
                                              want.status, want.idx, want.mlen));
                end
            end
        end
    end

    // stimulus
    initial begin
        t_stim_row      row;
        t_lookup_result want;
        t_mode             r_mode;
        logic [ADDR_W-1:0] r_addr;
        logic [LEN_W-1:0]  r_plen;
        logic [TAG_W-1:0]  r_tag;
        logic [ADDR_W-1:0] mk;
        int pick;
        int j;

        i_rst_n      <= 1'b0;
        i_valid      <= 1'b0;
        i_mode       <= 1'b0;
        i_address    <= '0;
        i_prefix_len <= '0;
        i_name_tag   <= '0;

        // empty table, then every slot filled with an edge-case entry
        dir_rows.push_back('{MODE_LOOKUP, 32'hFFFFFFFF, 6'd0,  16'h0000, 1, ST_NOMATCH,  4'd0,  6'd0});
        dir_rows.push_back('{MODE_INSERT, 32'h0A000000, 6'd8,  16'h0000, 1, ST_INSERTED, 4'd0,  6'd0});
        dir_rows.push_back('{MODE_INSERT, 32'h0A010000, 6'd16, 16'h0001, 1, ST_INSERTED, 4'd1,  6'd0});
        dir_rows.push_back('{MODE_INSERT, 32'h0A010200, 6'd24, 16'hFFFF, 1, ST_INSERTED, 4'd2,  6'd0});
        dir_rows.push_back('{MODE_INSERT, 32'hC0A80101, 6'd32, 16'h0000, 1, ST_INSERTED, 4'd3,  6'd0});
        dir_rows.push_back('{MODE_INSERT, 32'hFFFFFFFF, 6'd63, 16'h0002, 1, ST_INSERTED, 4'd4,  6'd0});
        dir_rows.push_back('{MODE_INSERT, 32'h00000000, 6'd0,  16'h8000, 1, ST_INSERTED, 4'd5,  6'd0});
        dir_rows.push_back('{MODE_INSERT, 32'h0A010000, 6'd16, 16'h0001, 1, ST_INSERTED, 4'd6,  6'd0});
        dir_rows.push_back('{MODE_INSERT, 32'hAC100000, 6'd12, 16'h1234, 1, ST_INSERTED, 4'd7,  6'd0});
        dir_rows.push_back('{MODE_INSERT, 32'hAC100000, 6'd12, 16'h4321, 1, ST_INSERTED, 4'd8,  6'd0});
        dir_rows.push_back('{MODE_INSERT, 32'h80000000, 6'd1,  16'h0000, 1, ST_INSERTED, 4'd9,  6'd0});
        dir_rows.push_back('{MODE_INSERT, 32'h12345678, 6'd33, 16'h0000, 1, ST_INSERTED, 4'd10, 6'd0});
        dir_rows.push_back('{MODE_INSERT, 32'hC0A80100, 6'd24, 16'h0002, 1, ST_INSERTED, 4'd11, 6'd0});
        dir_rows.push_back('{MODE_INSERT, 32'h55555555, 6'd31, 16'h00AA, 1, ST_INSERTED, 4'd12, 6'd0});
        dir_rows.push_back('{MODE_INSERT, 32'hAAAAAAAA, 6'd30, 16'h0000, 1, ST_INSERTED, 4'd13, 6'd0});
        dir_rows.push_back('{MODE_INSERT, 32'h0A0102FF, 6'd32, 16'hFFFF, 1, ST_INSERTED, 4'd14, 6'd0});
        dir_rows.push_back('{MODE_INSERT, 32'hFEDCBA98, 6'd20, 16'h7FFF, 1, ST_INSERTED, 4'd15, 6'd0});
        // table full
        dir_rows.push_back('{MODE_INSERT, 32'h01020304, 6'd8,  16'h0000, 1, ST_FULL,     4'd0,  6'd0});
        // lookups: longest wins, tag filters, ties, default route, no match
        dir_rows.push_back('{MODE_LOOKUP, 32'h0A0102FF, 6'd0,  16'hFFFF, 0, ST_MATCH, 4'd0, 6'd0});
        dir_rows.push_back('{MODE_LOOKUP, 32'h0A0102FF, 6'd0,  16'h0001, 0, ST_MATCH, 4'd0, 6'd0});
        dir_rows.push_back('{MODE_LOOKUP, 32'h0A7F0000, 6'd0,  16'h0000, 0, ST_MATCH, 4'd0, 6'd0});
        dir_rows.push_back('{MODE_LOOKUP, 32'h7FFFFFFF, 6'd0,  16'h0003, 0, ST_MATCH, 4'd0, 6'd0});
        dir_rows.push_back('{MODE_LOOKUP, 32'h00000000, 6'd0,  16'h8000, 0, ST_MATCH, 4'd0, 6'd0});
        dir_rows.push_back('{MODE_LOOKUP, 32'hFFFFFFFF, 6'd63, 16'hFFFF, 0, ST_MATCH, 4'd0, 6'd0});
        dir_rows.push_back('{MODE_LOOKUP, 32'hAC1FFFFF, 6'd0,  16'h4321, 0, ST_MATCH, 4'd0, 6'd0});

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table
        foreach (dir_rows[n]) begin
            row = dir_rows[n];
            offer_item(row.mode, row.addr, row.plen, row.tag);
            want = predict_peer_result(row.mode, row.addr, row.plen, row.tag);
            if (row.typed) begin
                want = '{row.status, row.idx, row.mlen};
            end
            pending_results.push_back(want);
        end

        // random traffic, one block per idle phase
        for (int ph = 0; ph < 3; ph++) begin
            if (ph > 0) begin
                drain_results();
            end
            idle_phase = ph;
            for (int n = 0; n < RAND_ITEMS; n++) begin
                pick   = $urandom_range(99);
                r_plen = 6'($urandom_range(63));
                if (pick < 8) begin
                    // insert into the full table
                    r_mode = MODE_INSERT;
                    r_addr = $urandom;
                    r_tag  = 16'($urandom);
                end else if (pick < 15 || tbl_count == 0) begin
                    // noise lookup
                    r_mode = MODE_LOOKUP;
                    r_addr = $urandom;
                    r_tag  = ($urandom_range(1) == 0) ? 16'h0000 : 16'($urandom);
                end else begin
                    // lookup aimed at a stored prefix
                    r_mode = MODE_LOOKUP;
                    j      = $urandom_range(tbl_count - 1);
                    mk     = len_mask(tbl_len[j]);
                    r_addr = (tbl_addr[j] & mk) | ($urandom & ~mk);
                    if ($urandom_range(3) == 0 && tbl_len[j] != 0) begin
                        r_addr ^= 32'h80000000 >> $urandom_range(tbl_len[j] - 1);
                    end
                    case ($urandom_range(3))
                        0: r_tag = 16'h0000;
                        1: r_tag = tbl_tag[j];
                        2: r_tag = tbl_tag[$urandom_range(tbl_count - 1)];
                        default: r_tag = 16'($urandom);
                    endcase
                end
                offer_item(r_mode, r_addr, r_plen, r_tag);
                pending_results.push_back(predict_peer_result(r_mode, r_addr, r_plen, r_tag));
            end
        end

        // drain and let the chain settle
        drain_results();
        repeat (2 * CHAIN_LAT) @(posedge i_clk);
        if (err_count == 0) begin
            $display("tb_peer_longest_prefix_lookup_top: done, clean");
        end else begin
            $display("tb_peer_longest_prefix_lookup_top: done, errors");
        end
        $finish;
    end

    // watchdog
    initial begin
        #2000000;
        $display("tb_peer_longest_prefix_lookup_top: done, errors");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/plr_pkg.sv
rtl/plr_cell.sv
rtl/peer_longest_prefix_lookup_top.sv
rtl/plr_checker.sv
sim/tb_peer_longest_prefix_lookup_top.sv
